// File: rtl/limit_order_book_matcher_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the order book matcher
// Shared property forms; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LOBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("order book matcher check failed");

// Consequent must hold in the cycle after the antecedent.
`define LOBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("order book matcher check failed");

`endif

// File: rtl/lobm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and codes shared by the order book matcher modules.
// ----------------------------------------------------------------------------
package lobm_pkg;

  // One resting order slot as held in the slot memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] price;
    logic [31:0] order_id;
    logic [23:0] remaining;
    logic [31:0] arrival;
  } slot_t;

  typedef enum logic [1:0] {
    SCAN_MATCH,
    SCAN_CANCEL,
    SCAN_FREE,
    SCAN_BEST
  } scan_kind_t;

  localparam logic [1:0] REC_TRADE       = 2'd0;
  localparam logic [1:0] REC_SUBMIT_DONE = 2'd1;
  localparam logic [1:0] REC_CANCEL_DONE = 2'd2;

  localparam logic [1:0] STATUS_OPEN    = 2'd0;
  localparam logic [1:0] STATUS_PARTIAL = 2'd1;
  localparam logic [1:0] STATUS_FILLED  = 2'd2;

  localparam logic CMD_SUBMIT  = 1'b0;
  localparam logic CMD_CANCEL  = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic SIDE_SELL   = 1'b1;
  localparam logic KIND_LIMIT  = 1'b0;
  localparam logic KIND_MARKET = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       scan_clear;
    scan_kind_t kind;
    logic       rd;
    logic       chk;
    logic       trade;
    logic       place;
    logic       kill;
    logic       close;
    logic       clr;
  } lobm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;
    logic rest_needed;
    logic match_go;
  } lobm_status_t;

endpackage

// File: rtl/limit_order_book_matcher_core.sv
`timescale 1ns / 1ps
// Sequence: a cancel scans its own book for the order, kills it if found, reads best
// prices over both books of the symbol and closes. A submit repeats a match scan and a
// fill per trade, rests a limit remainder by a free-slot scan and a placement, then reads
// best prices and closes. One item in flight; the next is taken in the cycle after the
// closing record is loaded, and a stalled record holds the sequencer until it is taken.
// Reset: synchronous; a clearing pass over all SYMBOLS*2*BOOK_DEPTH slots follows.
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Price-time priority order books for several symbols with trade output.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core
  import lobm_pkg::*;
#(
  parameter int SYMBOLS    = 4,
  parameter int BOOK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [1:0]  symbol_index,
  input  logic [31:0] order_id,
  input  logic        side,
  input  logic        order_kind,
  input  logic [31:0] limit_price,
  input  logic [23:0] quantity,
  input  logic [47:0] timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  record_kind,
  output logic [31:0] trade_price,
  output logic [23:0] trade_quantity,
  output logic [31:0] buy_order_id,
  output logic [31:0] sell_order_id,
  output logic [47:0] trade_time,
  output logic [1:0]  order_status,
  output logic        cancel_found,
  output logic        book_full,
  output logic [31:0] best_bid,
  output logic [31:0] best_ask,
  output logic        last_of_run
);

  localparam int NUM_SLOTS = SYMBOLS * 2 * BOOK_DEPTH;
  localparam int AW        = $clog2(NUM_SLOTS);
  localparam int IW        = $clog2(2 * BOOK_DEPTH);

  // The controller walks each book one slot per cycle through the slot
  // memory. Matching repeats a best-slot scan of the opposite book for every
  // fill, then a free-slot scan of the own book places a limit remainder,
  // and a final scan over both books of the symbol yields best bid and ask.
  lobm_cmd_t     cmd;
  lobm_status_t  stat;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] chk_idx;
  logic [AW-1:0] clr_idx;

  lobm_ctrl #(
    .SYMBOLS   (SYMBOLS),
    .BOOK_DEPTH(BOOK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_command(command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .scan_idx  (scan_idx),
    .chk_idx   (chk_idx),
    .clr_idx   (clr_idx)
  );

  // The datapath owns the item, the slot memory and the result register.
  // The result register lets the next scan run while a record waits.
  lobm_datapath #(
    .SYMBOLS   (SYMBOLS),
    .BOOK_DEPTH(BOOK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .scan_idx      (scan_idx),
    .chk_idx       (chk_idx),
    .clr_idx       (clr_idx),
    .command       (command),
    .symbol_index  (symbol_index),
    .order_id      (order_id),
    .side          (side),
    .order_kind    (order_kind),
    .limit_price   (limit_price),
    .quantity      (quantity),
    .timestamp     (timestamp),
    .record_kind   (record_kind),
    .trade_price   (trade_price),
    .trade_quantity(trade_quantity),
    .buy_order_id  (buy_order_id),
    .sell_order_id (sell_order_id),
    .trade_time    (trade_time),
    .order_status  (order_status),
    .cancel_found  (cancel_found),
    .book_full     (book_full),
    .best_bid      (best_bid),
    .best_ask      (best_ask),
    .last_of_run   (last_of_run)
  );

endmodule

// File: rtl/lobm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/lobm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_datapath
// Item registers, slot memory, scan comparators and result register.
// ----------------------------------------------------------------------------
module lobm_datapath
  import lobm_pkg::*;
#(
  parameter int SYMBOLS    = 4,
  parameter int BOOK_DEPTH = 32,
  localparam int NUM_SLOTS = SYMBOLS * 2 * BOOK_DEPTH,
  localparam int AW        = $clog2(NUM_SLOTS),
  localparam int IW        = $clog2(2 * BOOK_DEPTH),
  localparam int BW        = $clog2(2 * SYMBOLS)
) (
  input  logic               clk,
  input  logic               rst,
  input  lobm_cmd_t          cmd,
  output lobm_status_t       stat,
  input  logic [IW-1:0]      scan_idx,
  input  logic [IW-1:0]      chk_idx,
  input  logic [AW-1:0]      clr_idx,
  input  logic               command,
  input  logic [1:0]         symbol_index,
  input  logic [31:0]        order_id,
  input  logic               side,
  input  logic               order_kind,
  input  logic [31:0]        limit_price,
  input  logic [23:0]        quantity,
  input  logic [47:0]        timestamp,
  output logic [1:0]         record_kind,
  output logic [31:0]        trade_price,
  output logic [23:0]        trade_quantity,
  output logic [31:0]        buy_order_id,
  output logic [31:0]        sell_order_id,
  output logic [47:0]        trade_time,
  output logic [1:0]         order_status,
  output logic               cancel_found,
  output logic               book_full,
  output logic [31:0]        best_bid,
  output logic [31:0]        best_ask,
  output logic               last_of_run
);

  // Current item.
  logic          item_cmd;
  logic [BW-1:0] bid_book;
  logic [31:0]   item_id;
  logic          item_side;
  logic          item_market;
  logic [31:0]   item_limit;
  logic [23:0]   remaining;
  logic [47:0]   item_ts;
  logic          filled;
  logic          full;
  logic [31:0]   arrival_counter;

  // Scan results.
  logic          found;
  logic [AW-1:0] best_addr;
  logic [31:0]   best_price;
  logic [31:0]   best_id;
  logic [23:0]   best_rem;
  logic [31:0]   best_arr;
  logic          bid_found;
  logic [31:0]   bid_max;
  logic          ask_found;
  logic [31:0]   ask_min;

  logic [6:0]    sym_mod;
  logic [BW-1:0] scan_book;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] chk_addr;
  logic [$bits(slot_t)-1:0] rd_data;
  slot_t         rd_slot;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_slot;
  logic          want_high;
  logic          prio_hit;
  logic          better;
  logic [23:0]   fill_qty;

  function automatic logic [AW-1:0] addr_of(input logic [BW-1:0] book,
                                            input logic [IW-1:0] idx);
    addr_of = AW'(book) * AW'(BOOK_DEPTH) + AW'(idx);
  endfunction

  // The symbol index is below four, so three conditional subtractions fold
  // it into the configured number of symbols.
  always_comb begin
    sym_mod = {5'd0, symbol_index};
    for (int k = 0; k < 3; k++) begin
      if (sym_mod >= 7'(SYMBOLS)) begin
        sym_mod = sym_mod - 7'(SYMBOLS);
      end
    end
  end

  always_comb begin
    case (cmd.kind)
      SCAN_MATCH: scan_book = bid_book + BW'(item_side == SIDE_BUY);
      SCAN_BEST:  scan_book = bid_book;
      default:    scan_book = bid_book + BW'(item_side);
    endcase
  end

  assign rd_addr  = addr_of(scan_book, scan_idx);
  assign chk_addr = addr_of(scan_book, chk_idx);
  assign rd_slot  = slot_t'(rd_data);
  assign fill_qty = (remaining < best_rem) ? remaining : best_rem;

  // Price-time priority test of the entry coming back from memory.
  always_comb begin
    want_high = (cmd.kind == SCAN_MATCH) ? (item_side == SIDE_SELL)
                                         : (item_side == SIDE_BUY);
    if (!found) begin
      better = 1'b1;
    end else if (rd_slot.price == best_price) begin
      better = rd_slot.arrival < best_arr;
    end else if (want_high) begin
      better = rd_slot.price > best_price;
    end else begin
      better = rd_slot.price < best_price;
    end
    prio_hit = rd_slot.valid && better &&
               ((cmd.kind != SCAN_CANCEL) || (rd_slot.order_id == item_id));
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_addr;
    wr_slot = '0;
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
    end else if (cmd.trade) begin
      wr_en             = 1'b1;
      wr_slot.valid     = best_rem != fill_qty;
      wr_slot.price     = best_price;
      wr_slot.order_id  = best_id;
      wr_slot.remaining = best_rem - fill_qty;
      wr_slot.arrival   = best_arr;
    end else if (cmd.kill) begin
      wr_en = found;
    end else if (cmd.place) begin
      wr_en             = found;
      wr_slot.valid     = 1'b1;
      wr_slot.price     = item_limit;
      wr_slot.order_id  = item_id;
      wr_slot.remaining = remaining;
      wr_slot.arrival   = arrival_counter;
    end
  end

  lobm_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(NUM_SLOTS)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_slot),
    .rd_en  (cmd.rd),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    stat.rem_zero    = remaining == 24'd0;
    stat.rest_needed = (remaining != 24'd0) && (item_market == KIND_LIMIT);
    stat.match_go    = found && ((item_market == KIND_MARKET) ||
                       ((item_side == SIDE_SELL) ? (item_limit <= best_price)
                                                 : (item_limit >= best_price)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_counter <= '0;
    end else if (cmd.place && found) begin
      arrival_counter <= arrival_counter + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd    <= command;
      bid_book    <= BW'({sym_mod, 1'b0});
      item_id     <= order_id;
      item_side   <= side;
      item_market <= order_kind;
      item_limit  <= limit_price;
      remaining   <= quantity;
      item_ts     <= timestamp;
      filled      <= 1'b0;
      full        <= 1'b0;
    end
    if (cmd.trade) begin
      remaining <= remaining - fill_qty;
      filled    <= 1'b1;
    end
    if (cmd.place && !found) begin
      full <= 1'b1;
    end

    if (cmd.scan_clear) begin
      if (cmd.kind == SCAN_BEST) begin
        bid_found <= 1'b0;
        ask_found <= 1'b0;
      end else begin
        found <= 1'b0;
      end
    end else if (cmd.chk) begin
      case (cmd.kind)
        SCAN_FREE: begin
          if (!rd_slot.valid && !found) begin
            found     <= 1'b1;
            best_addr <= chk_addr;
          end
        end
        SCAN_BEST: begin
          if (chk_idx < IW'(BOOK_DEPTH)) begin
            if (rd_slot.valid && (!bid_found || rd_slot.price > bid_max)) begin
              bid_found <= 1'b1;
              bid_max   <= rd_slot.price;
            end
          end else begin
            if (rd_slot.valid && (!ask_found || rd_slot.price < ask_min)) begin
              ask_found <= 1'b1;
              ask_min   <= rd_slot.price;
            end
          end
        end
        default: begin
          if (prio_hit) begin
            found      <= 1'b1;
            best_addr  <= chk_addr;
            best_price <= rd_slot.price;
            best_id    <= rd_slot.order_id;
            best_rem   <= rd_slot.remaining;
            best_arr   <= rd_slot.arrival;
          end
        end
      endcase
    end

    if (cmd.trade) begin
      record_kind    <= REC_TRADE;
      trade_price    <= best_price;
      trade_quantity <= fill_qty;
      buy_order_id   <= (item_side == SIDE_SELL) ? best_id : item_id;
      sell_order_id  <= (item_side == SIDE_SELL) ? item_id : best_id;
      trade_time     <= item_ts;
      order_status   <= STATUS_OPEN;
      cancel_found   <= 1'b0;
      book_full      <= 1'b0;
      best_bid       <= '0;
      best_ask       <= '0;
      last_of_run    <= 1'b0;
    end else if (cmd.close) begin
      trade_price    <= '0;
      trade_quantity <= '0;
      buy_order_id   <= '0;
      sell_order_id  <= '0;
      trade_time     <= '0;
      best_bid       <= bid_found ? bid_max : 32'd0;
      best_ask       <= ask_found ? ask_min : 32'd0;
      last_of_run    <= 1'b1;
      if (item_cmd == CMD_CANCEL) begin
        record_kind  <= REC_CANCEL_DONE;
        order_status <= STATUS_OPEN;
        cancel_found <= found;
        book_full    <= 1'b0;
      end else begin
        record_kind  <= REC_SUBMIT_DONE;
        order_status <= (remaining == 24'd0) ? STATUS_FILLED :
                        (filled ? STATUS_PARTIAL : STATUS_OPEN);
        cancel_found <= 1'b0;
        book_full    <= full;
      end
    end
  end

endmodule

// File: rtl/lobm_ctrl.sv
`timescale 1ns / 1ps
`include "limit_order_book_matcher_core_defines.svh"
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer for clearing, scans, fills, placement and result handshakes.
// ----------------------------------------------------------------------------
module lobm_ctrl
  import lobm_pkg::*;
#(
  parameter int SYMBOLS    = 4,
  parameter int BOOK_DEPTH = 32,
  localparam int NUM_SLOTS = SYMBOLS * 2 * BOOK_DEPTH,
  localparam int AW        = $clog2(NUM_SLOTS),
  localparam int IW        = $clog2(2 * BOOK_DEPTH),
  localparam int NW        = $clog2(BOOK_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_command,
  output logic          out_valid,
  input  logic          out_stall,
  input  lobm_status_t  stat,
  output lobm_cmd_t     cmd,
  output logic [IW-1:0] scan_idx,
  output logic [IW-1:0] chk_idx,
  output logic [AW-1:0] clr_idx
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOP,
    ST_SCAN,
    ST_DONE,
    ST_TRADE,
    ST_RESTCHK,
    ST_PLACE,
    ST_KILL,
    ST_CLOSE
  } state_t;

  state_t        state;
  state_t        state_next;
  scan_kind_t    scan_kind;
  scan_kind_t    kind_next;
  logic          start;
  logic          issue_on;
  logic          chk;
  logic          chk_last;
  logic [NW-1:0] n;
  logic [IW-1:0] last_idx;
  logic          out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != ST_IDLE;
  assign last_idx = (scan_kind == SCAN_BEST) ? IW'(2 * BOOK_DEPTH - 1)
                                             : IW'(BOOK_DEPTH - 1);

  always_comb begin
    state_next = state;
    kind_next  = scan_kind;
    start      = 1'b0;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (clr_idx == AW'(NUM_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_command == CMD_CANCEL) begin
            start     = 1'b1;
            kind_next = SCAN_CANCEL;
          end else begin
            state_next = ST_LOOP;
          end
        end
      end
      ST_LOOP: begin
        if (stat.rem_zero || n == NW'(BOOK_DEPTH)) begin
          state_next = ST_RESTCHK;
        end else begin
          start     = 1'b1;
          kind_next = SCAN_MATCH;
        end
      end
      ST_SCAN: begin
        if (chk_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        case (scan_kind)
          SCAN_MATCH:  state_next = stat.match_go ? ST_TRADE : ST_RESTCHK;
          SCAN_CANCEL: state_next = ST_KILL;
          SCAN_FREE:   state_next = ST_PLACE;
          default:     state_next = ST_CLOSE;
        endcase
      end
      ST_TRADE: begin
        if (out_free) begin
          cmd.trade  = 1'b1;
          state_next = ST_LOOP;
        end
      end
      ST_RESTCHK: begin
        start     = 1'b1;
        kind_next = stat.rest_needed ? SCAN_FREE : SCAN_BEST;
      end
      ST_PLACE: begin
        cmd.place = 1'b1;
        start     = 1'b1;
        kind_next = SCAN_BEST;
      end
      ST_KILL: begin
        cmd.kill  = 1'b1;
        start     = 1'b1;
        kind_next = SCAN_BEST;
      end
      ST_CLOSE: begin
        if (out_free) begin
          cmd.close  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (start) begin
      state_next = ST_SCAN;
    end
    cmd.scan_clear = start;
    cmd.kind       = start ? kind_next : scan_kind;
    cmd.rd         = (state == ST_SCAN) && issue_on;
    cmd.chk        = chk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_kind <= SCAN_MATCH;
      scan_idx  <= '0;
      issue_on  <= 1'b0;
      chk       <= 1'b0;
      chk_idx   <= '0;
      chk_last  <= 1'b0;
      clr_idx   <= '0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_kind <= kind_next;
      chk       <= cmd.rd;
      chk_idx   <= scan_idx;
      chk_last  <= cmd.rd && (scan_idx == last_idx);
      if (cmd.clr) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (start) begin
        scan_idx <= '0;
        issue_on <= 1'b1;
      end else if (cmd.rd) begin
        if (scan_idx == last_idx) begin
          issue_on <= 1'b0;
        end else begin
          scan_idx <= scan_idx + IW'(1);
        end
      end
      if (cmd.load) begin
        n <= '0;
      end else if (cmd.trade) begin
        n <= n + NW'(1);
      end
      if (cmd.trade || cmd.close) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LOBM_ASSERT_NEXT(a_scan_entered, start, state == ST_SCAN)
  `LOBM_ASSERT_NOW(a_no_load_when_held, out_valid && out_stall, !(cmd.trade || cmd.close))
  `LOBM_ASSERT_NEXT(a_load_presents, cmd.trade || cmd.close, out_valid)
  `LOBM_ASSERT_NOW(a_trade_bound, cmd.trade, n < NW'(BOOK_DEPTH))

endmodule
